// File: src/lss_pkg.sv
// Shared types and constants for the LIFO stack with search.
`timescale 1ns / 1ps
`default_nettype none
package lss_pkg;

  localparam int DEPTH  = 256;
  localparam int WORD_W = 32;
  localparam int OCC_W  = 9;
  localparam int PTR_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_SEARCH = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic take_read;
    logic scan;
    logic load_out;
  } lss_cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_t act;
    logic    is_empty;
    logic    scan_done;
  } lss_stat_t;

endpackage
`default_nettype wire

// File: src/lss_ctrl.sv
// Request sequencer for the LIFO stack with search.
`timescale 1ns / 1ps
`default_nettype none
module lss_ctrl import lss_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire lss_stat_t stat,
  output lss_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        case (stat.act)
          ACT_POP, ACT_PEEK: state_nxt = stat.is_empty ? ST_FINISH : ST_RDWAIT;
          ACT_SEARCH:        state_nxt = ST_SCAN;
          default:           state_nxt = ST_FINISH;
        endcase
      end
      ST_RDWAIT: begin
        cmd.take_read = 1'b1;
        state_nxt     = ST_FINISH;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: src/lss_dpath.sv
// Entry store, stack pointer, search scan and result registers.
`timescale 1ns / 1ps
`default_nettype none
module lss_dpath import lss_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [1:0]         in_action,
  input  wire logic signed [31:0] in_operand_value,
  input  wire lss_cmd_t           cmd,
  output lss_stat_t               stat,
  output logic signed [31:0]      out_read_value,
  output logic                    out_empty_error,
  output logic                    out_overflow_error,
  output logic                    out_target_found,
  output logic                    out_stack_empty,
  output logic [8:0]              out_occupancy
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q;

  logic [PTR_W-1:0]  sp_r, sp_nxt;
  logic [PTR_W-1:0]  scan_r;
  logic              cmp_pend_r;
  action_t           act_r;
  logic [WORD_W-1:0] opnd_r;
  logic [WORD_W-1:0] rv_r;
  logic              empty_err_r, ovf_r, found_r;

  logic              is_empty, is_full;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [PTR_W-1:0]  sp_dec, scan_dec;

  assign is_empty = (sp_r == '0);
  assign is_full  = (sp_r == PTR_W'(DEPTH));
  assign sp_dec   = sp_r - PTR_W'(1);
  assign scan_dec = scan_r - PTR_W'(1);

  assign stat.act       = act_r;
  assign stat.is_empty  = is_empty;
  assign stat.scan_done = (scan_r == '0) && !cmp_pend_r;

  always_comb begin
    wr_en   = cmd.exec && (act_r == ACT_PUSH) && !is_full;
    rd_en   = 1'b0;
    rd_addr = sp_dec[ADDR_W-1:0];
    sp_nxt  = sp_r;
    if (cmd.exec && !is_empty && (act_r == ACT_POP || act_r == ACT_PEEK)) begin
      rd_en = 1'b1;
    end
    if (cmd.scan && (scan_r != '0)) begin
      rd_en   = 1'b1;
      rd_addr = scan_dec[ADDR_W-1:0];
    end
    if (wr_en) sp_nxt = sp_r + PTR_W'(1);
    if (cmd.exec && !is_empty && act_r == ACT_POP) sp_nxt = sp_dec;
  end

  // store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[sp_r[ADDR_W-1:0]] <= opnd_r;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r       <= '0;
      cmp_pend_r <= 1'b0;
    end else begin
      sp_r       <= sp_nxt;
      cmp_pend_r <= cmd.scan && (scan_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r       <= action_t'(in_action);
      opnd_r      <= in_operand_value;
      scan_r      <= sp_r;
      rv_r        <= '0;
      empty_err_r <= 1'b0;
      ovf_r       <= 1'b0;
      found_r     <= 1'b0;
    end
    if (cmd.exec) begin
      case (act_r)
        ACT_PUSH: ovf_r <= is_full;
        ACT_POP, ACT_PEEK: begin
          if (is_empty) begin
            rv_r        <= '1;
            empty_err_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (cmd.take_read) rv_r <= rd_q;
    if (cmd.scan) begin
      if (scan_r != '0) scan_r <= scan_dec;
      if (cmp_pend_r && (rd_q == opnd_r)) found_r <= 1'b1;
    end
    if (cmd.load_out) begin
      out_read_value     <= rv_r;
      out_empty_error    <= empty_err_r;
      out_overflow_error <= ovf_r;
      out_target_found   <= found_r;
      out_stack_empty    <= is_empty;
      out_occupancy      <= OCC_W'(sp_r);
    end
  end

endmodule
`default_nettype wire

// File: src/lifo_stack_with_search_unit.sv
// Top level of the LIFO stack with search: controller plus datapath.
//
// Usage:
//   Requests enter on the in_ channel (in_valid/in_ready); a transfer occurs
//   when both are high. in_action selects push, pop, peek or search and
//   in_operand_value carries the push value or the search target.
//   Every request gives exactly one result on the out_ channel
//   (out_valid/out_ready), with flags, stack_empty and occupancy after it.
// Timing:
//   One request is in flight at a time. Push, and pop or peek on an empty
//   stack, go from execute straight to finish; pop and peek on a non-empty
//   stack pass through a read-wait state (registered read of the entry
//   store). Search scans all n held entries through the same read port,
//   one per cycle, then goes to finish. The next request is taken in the
//   cycle after the result is loaded into the output register.
// Reset and stall:
//   rst_n (synchronous, active low) empties the stack and drops any pending
//   result; the store contents are not cleared. While out_ready is low the
//   result holds, one further request may be taken and worked, and its result
//   waits in the finish state until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
module lifo_stack_with_search_unit import lss_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_action,
  input  wire logic signed [31:0] in_operand_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_read_value,
  output logic                    out_empty_error,
  output logic                    out_overflow_error,
  output logic                    out_target_found,
  output logic                    out_stack_empty,
  output logic [8:0]              out_occupancy
);

  lss_cmd_t  cmd;
  lss_stat_t stat;

  // sequence each request: capture, execute, read or scan, then load result
  lss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // hold the store, pointer and output register
  lss_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_action          (in_action),
    .in_operand_value   (in_operand_value),
    .cmd                (cmd),
    .stat               (stat),
    .out_read_value     (out_read_value),
    .out_empty_error    (out_empty_error),
    .out_overflow_error (out_overflow_error),
    .out_target_found   (out_target_found),
    .out_stack_empty    (out_stack_empty),
    .out_occupancy      (out_occupancy)
  );

endmodule
`default_nettype wire
